@@ rtl/core/lmbs_pkg.sv @@
// Package for the label map boundary segment extractor.
// Holds field widths, register indexes, default sizes and the item passed
// from the input stage to the segment emitter. Depends on nothing.
package lmbs_pkg;

    localparam int COORD_W  = 12;
    localparam int COLOUR_W = 24;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int IMAGE_SIZE_RESET = 2048;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic [COLOUR_W-1:0] left;
        logic [COLOUR_W-1:0] above;
        logic [COORD_W-1:0]  start_x;
        logic [COORD_W-1:0]  start_y;
        logic [COORD_W-1:0]  next_x;
        logic [COORD_W-1:0]  next_y;
        logic                col_nz;
        logic                row_nz;
    } seg_item_t;

endpackage

@@ rtl/core/lmbs_front.sv @@
// Input stage of the boundary segment extractor: column and row counters,
// left colour, previous-row store and the registered pixel item.
// Depends on lmbs_pkg.
module lmbs_front #(
    parameter int MAX_WIDTH  = lmbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lmbs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_pixel_red,
    input  logic [7:0]                           s_pixel_green,
    input  logic [7:0]                           s_pixel_blue,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       width_size,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]      height_size,
    output logic                                 item_valid,
    output lmbs_pkg::seg_item_t                  item,
    input  logic                                 item_ready
);
    import lmbs_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [AW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [COLOUR_W-1:0] left_reg;
    logic                s1_valid_reg, s1_valid_next;
    logic [COLOUR_W-1:0] colour_reg;
    logic [COLOUR_W-1:0] prev_left_reg;
    logic [COLOUR_W-1:0] above_reg;
    logic [COORD_W-1:0]  start_x_reg, start_y_reg, next_x_reg, next_y_reg;
    logic                col_nz_reg, row_nz_reg;
    logic [COLOUR_W-1:0] row_mem [MAX_WIDTH];

    logic [COLOUR_W-1:0] colour;
    logic                accept;
    logic [CW-1:0]       col_inc;
    logic [HW-1:0]       row_inc;

    assign colour  = {s_pixel_red, s_pixel_green, s_pixel_blue};
    assign s_ready = !s1_valid_reg || item_ready;
    assign accept  = s_valid && s_ready;
    assign col_inc = CW'(col_reg) + CW'(1);
    assign row_inc = HW'(row_reg) + HW'(1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_inc >= width_size) begin
                col_next = '0;
                row_next = (row_inc >= height_size) ? '0 : RW'(row_inc);
            end else begin
                col_next = AW'(col_inc);
            end
        end
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (item_ready) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            if (accept) begin
                left_reg <= colour;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            above_reg        <= row_mem[col_reg];
            row_mem[col_reg] <= colour;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            colour_reg    <= colour;
            prev_left_reg <= left_reg;
            start_x_reg   <= COORD_W'(col_reg);
            start_y_reg   <= COORD_W'(row_reg);
            next_x_reg    <= COORD_W'(col_inc);
            next_y_reg    <= COORD_W'(row_inc);
            col_nz_reg    <= (col_reg != '0);
            row_nz_reg    <= (row_reg != '0);
        end
    end

    assign item_valid   = s1_valid_reg;
    assign item.colour  = colour_reg;
    assign item.left    = prev_left_reg;
    assign item.above   = above_reg;
    assign item.start_x = start_x_reg;
    assign item.start_y = start_y_reg;
    assign item.next_x  = next_x_reg;
    assign item.next_y  = next_y_reg;
    assign item.col_nz  = col_nz_reg;
    assign item.row_nz  = row_nz_reg;

endmodule

@@ rtl/core/lmbs_emit.sv @@
// Segment emitter: compares a pixel with its left and upper neighbours and
// sends the vertical, then the horizontal segment through the output register.
// Depends on lmbs_pkg.
module lmbs_emit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        item_valid,
    input  lmbs_pkg::seg_item_t         item,
    output logic                        item_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lmbs_pkg::COORD_W-1:0] m_start_x,
    output logic [lmbs_pkg::COORD_W-1:0] m_start_y,
    output logic [lmbs_pkg::COORD_W-1:0] m_end_x,
    output logic [lmbs_pkg::COORD_W-1:0] m_end_y,
    output logic                        m_is_horizontal,
    output logic                        m_last_of_run
);
    import lmbs_pkg::*;

    logic               m_valid_reg, m_valid_next;
    logic               vert_sent_reg, vert_sent_next;
    logic [COORD_W-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic               horiz_reg, last_reg;

    logic need_v, need_h, send_v, seg_last, out_free, load;

    assign need_v   = item.col_nz && (item.colour != item.left);
    assign need_h   = item.row_nz && (item.colour != item.above);
    assign send_v   = need_v && !vert_sent_reg;
    assign seg_last = send_v ? !need_h : 1'b1;
    assign out_free = !m_valid_reg || m_ready;
    assign load     = item_valid && (send_v || need_h) && out_free;
    assign item_ready = !(send_v || need_h) || (out_free && seg_last);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        vert_sent_next = vert_sent_reg;
        if (load && send_v && !seg_last) begin
            vert_sent_next = 1'b1;
        end else if (item_valid && item_ready) begin
            vert_sent_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            vert_sent_reg <= 1'b0;
        end else begin
            m_valid_reg   <= m_valid_next;
            vert_sent_reg <= vert_sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            start_x_reg <= item.start_x;
            start_y_reg <= item.start_y;
            end_x_reg   <= send_v ? item.start_x : item.next_x;
            end_y_reg   <= send_v ? item.next_y : item.start_y;
            horiz_reg   <= !send_v;
            last_reg    <= seg_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_start_x       = start_x_reg;
    assign m_start_y       = start_y_reg;
    assign m_end_x         = end_x_reg;
    assign m_end_y         = end_y_reg;
    assign m_is_horizontal = horiz_reg;
    assign m_last_of_run   = last_reg;

endmodule

@@ rtl/core/label_map_boundary_segments.sv @@
// Top level of the label map boundary segment extractor.
// Holds the size registers and joins lmbs_front and lmbs_emit; uses lmbs_pkg.
//
//   Port group   Direction  Contents
//   s_*          in         one RGB label pixel per transaction, raster order
//   m_*          out        one unit boundary segment per transaction
//   cfg_*        in         size register writes, no handshake
//
// A pixel with two segments waits in the pixel register until both are sent, as the
// single output register sends one segment per cycle while the output is not stalled.
// Each pixel is held in the pixel register and its segments in the output register.
// Reset clears the counters and the left colour and sets each size register to
// IMAGE_SIZE_RESET, capped at its maximum; the previous-row store is not cleared and
// needs no clearing pass. While the output is stalled, pixels without segments still
// pass; the first pixel that needs a segment waits in the pixel register and stalls the input.
module label_map_boundary_segments #(
    parameter int MAX_WIDTH  = lmbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lmbs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_pixel_red,
    input  logic [7:0]                     s_pixel_green,
    input  logic [7:0]                     s_pixel_blue,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lmbs_pkg::COORD_W-1:0]   m_start_x,
    output logic [lmbs_pkg::COORD_W-1:0]   m_start_y,
    output logic [lmbs_pkg::COORD_W-1:0]   m_end_x,
    output logic [lmbs_pkg::COORD_W-1:0]   m_end_y,
    output logic                           m_is_horizontal,
    output logic                           m_last_of_run,
    input  logic                           cfg_wr_en,
    input  logic [lmbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lmbs_pkg::CFG_W-1:0]     cfg_wr_data
);
    import lmbs_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RESET_W = (IMAGE_SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : IMAGE_SIZE_RESET;
    localparam int RESET_H = (IMAGE_SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : IMAGE_SIZE_RESET;

    logic [CW-1:0] width_reg, width_next, width_clamped;
    logic [HW-1:0] height_reg, height_next, height_clamped;

    logic      item_valid, item_ready;
    seg_item_t item;

    always_comb begin
        if (cfg_wr_data == '0) begin
            width_clamped  = CW'(1);
            height_clamped = HW'(1);
        end else begin
            width_clamped  = (32'(cfg_wr_data) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(cfg_wr_data);
            height_clamped = (32'(cfg_wr_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT)
                                                             : HW'(cfg_wr_data);
        end
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    width_next = width_clamped;
                end
                REG_IMAGE_HEIGHT: begin
                    height_next = height_clamped;
                end
                default: begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CW'(RESET_W);
            height_reg <= HW'(RESET_H);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    lmbs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_red   (s_pixel_red),
        .s_pixel_green (s_pixel_green),
        .s_pixel_blue  (s_pixel_blue),
        .width_size    (width_reg),
        .height_size   (height_reg),
        .item_valid    (item_valid),
        .item          (item),
        .item_ready    (item_ready)
    );

    lmbs_emit u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (item_valid),
        .item            (item),
        .item_ready      (item_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_start_x       (m_start_x),
        .m_start_y       (m_start_y),
        .m_end_x         (m_end_x),
        .m_end_y         (m_end_y),
        .m_is_horizontal (m_is_horizontal),
        .m_last_of_run   (m_last_of_run)
    );

endmodule

@@ rtl/core/lmbs_checker.sv @@
// Port-level checks for the label map boundary segment extractor, bound to
// the top level. Depends on lmbs_pkg.
module lmbs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [lmbs_pkg::COORD_W-1:0]   m_start_x,
    input logic [lmbs_pkg::COORD_W-1:0]   m_start_y,
    input logic [lmbs_pkg::COORD_W-1:0]   m_end_x,
    input logic [lmbs_pkg::COORD_W-1:0]   m_end_y,
    input logic                           m_is_horizontal,
    input logic                           m_last_of_run
);
    import lmbs_pkg::*;

    logic [COORD_W-1:0] one;
    assign one = COORD_W'(1);

    // A segment is always one grid step long in its own direction.
    a_unit_segment: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_horizontal ? (m_end_x == m_start_x + one && m_end_y == m_start_y)
                                     : (m_end_y == m_start_y + one && m_end_x == m_start_x)))
        else $error("segment is not a unit step");

    // A horizontal segment always closes the run of its pixel.
    a_horizontal_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_horizontal) |-> m_last_of_run)
        else $error("horizontal segment not marked last");

    // A vertical segment that is not last is followed at once by the
    // horizontal segment of the same pixel.
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_is_horizontal && !m_last_of_run) |=>
        (m_valid && m_is_horizontal && m_start_x == $past(m_start_x)
         && m_start_y == $past(m_start_y)))
        else $error("second segment of a pixel missing");

    // A stalled segment holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_start_x) && $stable(m_start_y)
                                   && $stable(m_is_horizontal) && $stable(m_last_of_run)))
        else $error("output changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind label_map_boundary_segments lmbs_checker u_lmbs_checker (.*);
